// File: rtl/assert_macros.svh
// Assertion helpers for the top-k score heap core.
// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define TKSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication that is checked in the same cycle.
`define TKSH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/tksh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksh_pkg
// Shared widths, codes and the command and status bundles of the heap core.
// ----------------------------------------------------------------------------
package tksh_pkg;

  localparam int CNT_W          = 7;
  localparam int CAP_W          = 7;
  localparam int SLOT_W         = 6;
  localparam int PAY_W          = 64;
  localparam int STORE_DEPTH_DEF = 64;
  localparam int SCORE_BITS_DEF  = 32;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic             REG_CAPACITY = 1'b0;

  localparam logic [1:0] MODE_OFFER = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic accept;
    logic build_load;
    logic build_fetch;
    logic sift_step;
    logic build_next;
    logic read_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fills;
    logic replace;
    logic is_read;
    logic sift_done;
    logic build_more;
  } status_t;

endpackage

// File: rtl/top_k_smallest_score_heap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_smallest_score_heap_core
// Bounded store of the candidates with the smallest signed scores.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. An append, a clear
// or an unused mode goes from acceptance through the finish state to the
// result register; a read first captures the addressed slot. An offer that
// replaces the root first sifts the new root down through the heap. The
// append that fills the store also builds the heap, loading, fetching and
// sifting each inner node in turn, from the last inner node to the root.
// The sift loop moves one heap level per cycle by reading both children
// from the two read ports of the store.
// A waiting result does not block the next request from being accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module top_k_smallest_score_heap_core #(
  parameter int STORE_DEPTH = tksh_pkg::STORE_DEPTH_DEF,
  parameter int SCORE_BITS  = tksh_pkg::SCORE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [tksh_pkg::PAY_W-1:0]         cand_x_i,
  input  logic [tksh_pkg::PAY_W-1:0]         cand_y_i,
  input  logic signed [tksh_pkg::PAY_W-1:0]  cand_z_i,
  input  logic signed [SCORE_BITS-1:0]       cand_score_i,
  input  logic [tksh_pkg::SLOT_W-1:0]        slot_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               accepted_o,
  output logic [tksh_pkg::CNT_W-1:0]         entry_count_o,
  output logic signed [SCORE_BITS-1:0]       worst_score_o,
  output logic [tksh_pkg::PAY_W-1:0]         read_x_o,
  output logic [tksh_pkg::PAY_W-1:0]         read_y_o,
  output logic signed [tksh_pkg::PAY_W-1:0]  read_z_o,
  output logic signed [SCORE_BITS-1:0]       read_score_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tksh_pkg::APB_AW-1:0]        paddr,
  input  logic [tksh_pkg::APB_DW-1:0]        pwdata,
  output logic [tksh_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  logic [tksh_pkg::CAP_W-1:0] cap;
  tksh_pkg::cmd_t             cmd;
  tksh_pkg::status_t          status;
  logic [5:0]                 cmd_vec;

  tksh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  tksh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tksh_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .SCORE_BITS  (SCORE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap),
    .mode_i        (mode_i),
    .cand_x_i      (cand_x_i),
    .cand_y_i      (cand_y_i),
    .cand_z_i      (cand_z_i),
    .cand_score_i  (cand_score_i),
    .slot_i        (slot_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .accepted_o    (accepted_o),
    .entry_count_o (entry_count_o),
    .worst_score_o (worst_score_o),
    .read_x_o      (read_x_o),
    .read_y_o      (read_y_o),
    .read_z_o      (read_z_o),
    .read_score_o  (read_score_o)
  );

  assign cmd_vec = {cmd.accept, cmd.build_load, cmd.build_fetch, cmd.sift_step,
                    cmd.read_capture, cmd.out_load};

  `TKSH_ASSERT(a_one_cmd, $onehot0(cmd_vec), "more than one datapath command at once")
  `TKSH_ASSERT_IMPL(a_idle_no_sift, !in_stall_o, !cmd.sift_step && !cmd.build_load, "idle work")
  `TKSH_ASSERT_IMPL(a_offer_no_read, out_valid_o && accepted_o, read_x_o == '0, "offer read")
  `TKSH_ASSERT_IMPL(a_acc_count, out_valid_o && accepted_o, entry_count_o != '0, "empty store")

endmodule

// File: rtl/tksh_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksh_cfg_regs
// APB register bank holding the capacity register.
// ----------------------------------------------------------------------------
module tksh_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tksh_pkg::APB_AW-1:0]   paddr,
  input  logic [tksh_pkg::APB_DW-1:0]   pwdata,
  output logic [tksh_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [tksh_pkg::CAP_W-1:0]    cap_o
);

  logic [tksh_pkg::CAP_W-1:0] cap_q;
  logic                       sel_cap;

  assign sel_cap = (paddr[tksh_pkg::APB_AW-1] == tksh_pkg::REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = sel_cap ? tksh_pkg::APB_DW'(cap_q) : '0;
  assign cap_o   = cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= tksh_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      cap_q <= pwdata[tksh_pkg::CAP_W-1:0];
    end
  end

endmodule

// File: rtl/tksh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksh_ctrl
// Sequencer for append, root replacement, heap build, read and output hand-off.
// ----------------------------------------------------------------------------
module tksh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tksh_pkg::status_t status_i,
  output tksh_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE        = 7'b0000001,
    S_READ_WAIT   = 7'b0000010,
    S_BUILD_LOAD  = 7'b0000100,
    S_BUILD_FETCH = 7'b0001000,
    S_SIFT_BUILD  = 7'b0010000,
    S_SIFT_OFFER  = 7'b0100000,
    S_FINISH      = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic           out_valid_q, out_valid_d;
  tksh_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          if (status_i.fills) begin
            state_d = S_BUILD_LOAD;
          end else if (status_i.replace) begin
            state_d = S_SIFT_OFFER;
          end else if (status_i.is_read) begin
            state_d = S_READ_WAIT;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_READ_WAIT: begin
        cmd.read_capture = 1'b1;
        state_d          = S_FINISH;
      end
      S_BUILD_LOAD: begin
        cmd.build_load = 1'b1;
        state_d        = S_BUILD_FETCH;
      end
      S_BUILD_FETCH: begin
        cmd.build_fetch = 1'b1;
        state_d         = S_SIFT_BUILD;
      end
      S_SIFT_BUILD: begin
        cmd.sift_step = 1'b1;
        if (status_i.sift_done) begin
          if (status_i.build_more) begin
            cmd.build_next = 1'b1;
            state_d        = S_BUILD_LOAD;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SIFT_OFFER: begin
        cmd.sift_step = 1'b1;
        if (status_i.sift_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: rtl/tksh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksh_datapath
// Candidate store with two read ports, heap index logic and result registers.
// ----------------------------------------------------------------------------
module tksh_datapath #(
  parameter int STORE_DEPTH = tksh_pkg::STORE_DEPTH_DEF,
  parameter int SCORE_BITS  = tksh_pkg::SCORE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tksh_pkg::CAP_W-1:0]         cap_i,
  input  logic [1:0]                         mode_i,
  input  logic [tksh_pkg::PAY_W-1:0]         cand_x_i,
  input  logic [tksh_pkg::PAY_W-1:0]         cand_y_i,
  input  logic signed [tksh_pkg::PAY_W-1:0]  cand_z_i,
  input  logic signed [SCORE_BITS-1:0]       cand_score_i,
  input  logic [tksh_pkg::SLOT_W-1:0]        slot_i,
  input  tksh_pkg::cmd_t                     cmd_i,
  output tksh_pkg::status_t                  status_o,
  output logic                               accepted_o,
  output logic [tksh_pkg::CNT_W-1:0]         entry_count_o,
  output logic signed [SCORE_BITS-1:0]       worst_score_o,
  output logic [tksh_pkg::PAY_W-1:0]         read_x_o,
  output logic [tksh_pkg::PAY_W-1:0]         read_y_o,
  output logic signed [tksh_pkg::PAY_W-1:0]  read_z_o,
  output logic signed [SCORE_BITS-1:0]       read_score_o
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = tksh_pkg::CNT_W;
  localparam int IW = CW + 1;

  typedef struct packed {
    logic [tksh_pkg::PAY_W-1:0] x;
    logic [tksh_pkg::PAY_W-1:0] y;
    logic [tksh_pkg::PAY_W-1:0] z;
    logic [SCORE_BITS-1:0]      score;
  } entry_t;

  entry_t mem [STORE_DEPTH];

  entry_t rd_a_q, rd_b_q;
  entry_t hole_q, rdres_q, out_rd_q;
  logic [CW-1:0] count_q, idx_q, bidx_q, out_cnt_q;
  logic [SCORE_BITS-1:0] root_q, out_worst_q;
  logic have_l_q, have_r_q, acc_q, slot_ok_q, out_acc_q;

  logic [CW-1:0] eff_cap;
  entry_t        in_entry, child, wdata;
  logic          is_offer, not_full, append, fills, replace, is_read;
  logic [IW-1:0] left_c, right_c, nl, nr;
  logic [CW-1:0] c_idx, n_base;
  logic          pick_r, move, set_kids, we;
  logic [AW-1:0] addr_a, addr_b, waddr;

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_i) > STORE_DEPTH) begin
      eff_cap = CW'(STORE_DEPTH);
    end else begin
      eff_cap = cap_i;
    end
  end

  assign in_entry = '{x: cand_x_i, y: cand_y_i, z: cand_z_i, score: cand_score_i};

  assign is_offer = (mode_i == tksh_pkg::MODE_OFFER);
  assign is_read  = (mode_i == tksh_pkg::MODE_READ);
  assign not_full = (count_q < eff_cap);
  assign append   = is_offer && not_full;
  assign fills    = append && ((count_q + CW'(1)) == eff_cap);
  assign replace  = is_offer && !not_full && ($signed(cand_score_i) < $signed(root_q));

  // Children of the node being sifted; the larger one moves up into the hole.
  assign left_c  = {idx_q, 1'b1};
  assign right_c = {idx_q, 1'b0} + IW'(2);
  assign pick_r  = have_r_q && ($signed(rd_a_q.score) < $signed(rd_b_q.score));
  assign child   = pick_r ? rd_b_q : rd_a_q;
  assign c_idx   = pick_r ? right_c[CW-1:0] : left_c[CW-1:0];
  assign move    = have_l_q && ($signed(hole_q.score) < $signed(child.score));

  always_comb begin
    n_base = c_idx;
    if (cmd_i.accept) begin
      n_base = '0;
    end else if (cmd_i.build_fetch) begin
      n_base = idx_q;
    end
  end

  assign nl       = {n_base, 1'b1};
  assign nr       = {n_base, 1'b0} + IW'(2);
  assign set_kids = (cmd_i.accept && replace) || cmd_i.build_fetch || (cmd_i.sift_step && move);

  always_comb begin
    addr_a = AW'(nl);
    addr_b = AW'(nr);
    if (cmd_i.accept && is_read) begin
      addr_a = AW'(slot_i);
    end else if (cmd_i.build_load) begin
      addr_a = AW'(bidx_q);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(count_q);
    wdata = in_entry;
    if (cmd_i.accept && append) begin
      we = 1'b1;
    end else if (cmd_i.sift_step) begin
      we    = 1'b1;
      waddr = AW'(idx_q);
      wdata = move ? child : hole_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      if (append) begin
        count_q <= count_q + CW'(1);
      end else if (mode_i == tksh_pkg::MODE_CLEAR) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && (waddr == '0)) begin
      root_q <= wdata.score;
    end
    if (cmd_i.accept) begin
      hole_q    <= in_entry;
      acc_q     <= append || replace;
      slot_ok_q <= (int'(slot_i) < STORE_DEPTH);
      rdres_q   <= '0;
    end
    if (cmd_i.accept && fills) begin
      bidx_q <= (eff_cap - CW'(1)) >> 1;
    end else if (cmd_i.build_next) begin
      bidx_q <= bidx_q - CW'(1);
    end
    if (cmd_i.accept && replace) begin
      idx_q <= '0;
    end else if (cmd_i.build_load) begin
      idx_q <= bidx_q;
    end else if (cmd_i.sift_step && move) begin
      idx_q <= c_idx;
    end
    if (set_kids) begin
      have_l_q <= (nl < {1'b0, eff_cap});
      have_r_q <= (nr < {1'b0, eff_cap});
    end
    if (cmd_i.build_fetch) begin
      hole_q <= rd_a_q;
    end
    if (cmd_i.read_capture) begin
      rdres_q <= slot_ok_q ? rd_a_q : '0;
    end
    if (cmd_i.out_load) begin
      out_acc_q   <= acc_q;
      out_cnt_q   <= count_q;
      out_worst_q <= (count_q >= eff_cap) ? root_q : '0;
      out_rd_q    <= rdres_q;
    end
  end

  assign status_o.fills      = fills;
  assign status_o.replace    = replace;
  assign status_o.is_read    = is_read;
  assign status_o.sift_done  = !move;
  assign status_o.build_more = (bidx_q != '0);

  assign accepted_o    = out_acc_q;
  assign entry_count_o = out_cnt_q;
  assign worst_score_o = out_worst_q;
  assign read_x_o      = out_rd_q.x;
  assign read_y_o      = out_rd_q.y;
  assign read_z_o      = out_rd_q.z;
  assign read_score_o  = out_rd_q.score;

endmodule
